/* rtl/core/scdf_pkg.sv */
// shared types and constants of the sigma-clip disparity filter
`default_nettype none
package scdf_pkg;
  localparam int unsigned SigmaBits = 12;
  localparam logic [0:0] RegSigmaX = 1'b0;
  localparam logic [0:0] RegSigmaY = 1'b1;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic clr;
    logic sum_start;
    logic sum_step;
    logic div_start;
    logic div_step;
    logic div_fin;
    logic sqrt_start;
    logic sqrt_step;
    logic thr_calc;
    logic cnt_start;
    logic cnt_step;
    logic emit_start;
    logic emit_step;
  } scdf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic idx_last;
    logic step_last;
  } scdf_sts_t;
endpackage
`default_nettype wire

/* rtl/core/sigma_clip_disparity_filter_top.sv */
// top level of the sigma-clip disparity filter
// Pairs load one per cycle while busy is low; a pair that is not marked final keeps
// busy low. After the pair marked final the block stays busy through mean division,
// a squared-deviation pass, variance division, a bit-serial root, a count pass, an emit
// pass and a clear state. Results come one per cycle on res_valid_o from the emit pass;
// all passes share one stored-disparity read port. The receiver cannot stall, so
// results must be taken as they appear.
`default_nettype none
module sigma_clip_disparity_filter_top
  import scdf_pkg::*;
#(
  parameter int unsigned MAX_PAIRS  = 64,
  parameter int unsigned COORD_BITS = 24
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [COORD_BITS-1:0] left_col_i,
  input  wire logic [COORD_BITS-1:0] left_row_i,
  input  wire logic [COORD_BITS-1:0] right_col_i,
  input  wire logic [COORD_BITS-1:0] right_row_i,
  input  wire logic                  final_pair_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_idx_i,
  input  wire logic [SigmaBits-1:0]  cfg_data_i,
  output logic                       res_valid_o,
  output logic [5:0]                 pair_index_o,
  output logic                       keep_pair_o,
  output logic [6:0]                 dropped_total_o,
  output logic                       run_end_o
);
  scdf_cmd_t cmd;
  scdf_sts_t sts;

  scdf_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .final_pair_i,
    .sts_i(sts), .cmd_o(cmd), .busy_o(busy)
  );

  scdf_datapath #(.MaxPairs(MAX_PAIRS), .CoordBits(COORD_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .left_col_i, .left_row_i, .right_col_i, .right_row_i,
    .cfg_we_i, .cfg_idx_i(cfg_idx_i[0]), .cfg_idx_ok_i(cfg_idx_i[1] == 1'b0),
    .cfg_data_i, .res_valid_o, .pair_index_o, .keep_pair_o,
    .dropped_total_o, .run_end_o
  );
endmodule
`default_nettype wire

/* rtl/core/scdf_ctrl.sv */
// controller state machine of the sigma-clip disparity filter
`default_nettype none
module scdf_ctrl
  import scdf_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire logic      final_pair_i,
  input  scdf_sts_t      sts_i,
  output scdf_cmd_t      cmd_o,
  output logic           busy_o
);
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMeanS = 4'd1;
  localparam logic [3:0] StMean  = 4'd2;
  localparam logic [3:0] StSqS   = 4'd3;
  localparam logic [3:0] StSq    = 4'd4;
  localparam logic [3:0] StVarS  = 4'd5;
  localparam logic [3:0] StVar   = 4'd6;
  localparam logic [3:0] StRoot  = 4'd7;
  localparam logic [3:0] StThr   = 4'd8;
  localparam logic [3:0] StCnt   = 4'd9;
  localparam logic [3:0] StEmit  = 4'd10;
  localparam logic [3:0] StClr   = 4'd11;

  logic [3:0] state_q, state_d;
  logic       acc;

  assign acc    = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (acc) begin
          cmd_o.load = 1'b1;
          if (final_pair_i) state_d = StMeanS;
        end
      end
      StMeanS: begin
        cmd_o.div_start = 1'b1;
        state_d = StMean;
      end
      StMean: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) state_d = StSqS;
      end
      StSqS: begin
        cmd_o.div_fin = 1'b1;
        cmd_o.sum_start = 1'b1;
        state_d = StSq;
      end
      StSq: begin
        cmd_o.sum_step = 1'b1;
        if (sts_i.idx_last) state_d = StVarS;
      end
      StVarS: begin
        cmd_o.div_start = 1'b1;
        state_d = StVar;
      end
      StVar: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = StRoot;
        end
      end
      StRoot: begin
        if (!sts_i.step_last) cmd_o.sqrt_start = 1'b1;
        cmd_o.sqrt_step = 1'b1;
        state_d = StThr;
      end
      StThr: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.step_last) begin
          cmd_o.thr_calc = 1'b1;
          cmd_o.cnt_start = 1'b1;
          state_d = StCnt;
        end
      end
      StCnt: begin
        cmd_o.cnt_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = StEmit;
          cmd_o.emit_start = 1'b1;
        end
      end
      StEmit: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.idx_last) state_d = StClr;
      end
      StClr: begin
        cmd_o.clr = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end
endmodule
`default_nettype wire

/* rtl/core/scdf_datapath.sv */
// datapath: disparity stores, sums, divider, root and band compare
`default_nettype none
module scdf_datapath
  import scdf_pkg::*;
#(
  parameter int unsigned MaxPairs  = 64,
  parameter int unsigned CoordBits = 24
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  scdf_cmd_t                 cmd_i,
  output scdf_sts_t                 sts_o,
  input  wire logic [CoordBits-1:0] left_col_i,
  input  wire logic [CoordBits-1:0] left_row_i,
  input  wire logic [CoordBits-1:0] right_col_i,
  input  wire logic [CoordBits-1:0] right_row_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic                 cfg_idx_ok_i,
  input  wire logic [SigmaBits-1:0] cfg_data_i,
  output logic                      res_valid_o,
  output logic [5:0]                pair_index_o,
  output logic                      keep_pair_o,
  output logic [6:0]                dropped_total_o,
  output logic                      run_end_o
);
  localparam int unsigned IdxW = $clog2(MaxPairs);
  localparam int unsigned CntW = $clog2(MaxPairs + 1);
  localparam int unsigned SumW = CoordBits + CntW;
  localparam int unsigned SqW  = 64;
  localparam int unsigned RtW  = 32;
  localparam int unsigned ThrW = RtW + SigmaBits;
  localparam logic [6:0]  SqrtSteps = 7'd32;

  logic [CoordBits-1:0] mem_x [MaxPairs];
  logic [CoordBits-1:0] mem_y [MaxPairs];
  logic [CoordBits-1:0] rd_x_q, rd_y_q;

  logic [SigmaBits-1:0] sig_x_q, sig_y_q;
  logic [CntW-1:0]      cnt_q;
  logic [SumW-1:0]      sum_x_q, sum_y_q;
  logic [IdxW-1:0]      ridx_q;
  logic                 rd_v_q;
  logic [CoordBits-1:0] dx, dy;
  logic [IdxW-1:0]      ridx_n;

  // divider: both axes share the loop, numerator width 64
  logic [SqW-1:0]       num_x_q, num_y_q;
  logic [SqW-1:0]       quo_x_q, quo_y_q;
  logic [CntW-1:0]      rem_x_q, rem_y_q;
  logic [6:0]           dstep_q;
  logic                 phase_q; // 0 mean, 1 variance
  logic [CoordBits-1:0] mean_x_q, mean_y_q;
  logic [SqW-1:0]       sq_x_q, sq_y_q;
  logic [CoordBits:0]   dvx, dvy;
  logic [2*CoordBits+1:0] px, py;

  logic [SqW-1:0]       sv_x_q, sv_y_q, sr_x_q, sr_y_q;
  logic [RtW-1:0]       rt_x_q, rt_y_q;
  logic [6:0]           sstep_q;
  logic [ThrW-1:0]      thr_x_q, thr_y_q;
  logic [6:0]           drop_q;
  logic [IdxW-1:0]      oidx_q;
  logic                 emit_q;

  assign dx = (left_col_i >= right_col_i) ? left_col_i - right_col_i
                                          : right_col_i - left_col_i;
  assign dy = (left_row_i >= right_row_i) ? left_row_i - right_row_i
                                          : right_row_i - left_row_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && (cnt_q < CntW'(MaxPairs))) begin
      mem_x[cnt_q[IdxW-1:0]] <= dx;
      mem_y[cnt_q[IdxW-1:0]] <= dy;
    end
    rd_x_q <= mem_x[ridx_n];
    rd_y_q <= mem_y[ridx_n];
  end

  always_comb begin
    ridx_n = ridx_q;
    if (cmd_i.sum_start || cmd_i.cnt_start || cmd_i.emit_start) ridx_n = '0;
    else if (cmd_i.sum_step || cmd_i.cnt_step || cmd_i.emit_step) ridx_n = ridx_q + 1'b1;
  end

  assign sts_o.idx_last  = (CntW'(ridx_q) == cnt_q - 1'b1);
  assign sts_o.step_last = phase_q ? (sstep_q == SqrtSteps && cmd_i.sqrt_step) ||
                                     (dstep_q == 7'd64 && !cmd_i.sqrt_step)
                                   : (dstep_q == 7'd64);

  function automatic logic [CoordBits:0] sdiff(input logic [CoordBits-1:0] a,
                                              input logic [CoordBits-1:0] b);
    sdiff = (a >= b) ? {1'b0, a - b} : {1'b0, b - a};
  endfunction

  assign dvx = sdiff(rd_x_q, mean_x_q);
  assign dvy = sdiff(rd_y_q, mean_y_q);

  // in-band test on registered data
  function automatic logic inb(input logic [CoordBits-1:0] d,
                               input logic [CoordBits-1:0] m,
                               input logic [ThrW-1:0] t);
    logic [ThrW:0] dd, mm, tt;
    dd = (ThrW+1)'(d);
    mm = (ThrW+1)'(m);
    tt = {1'b0, t};
    inb = (dd + tt >= mm) && (dd <= mm + tt);
  endfunction

  logic keep_now;
  assign keep_now = inb(rd_x_q, mean_x_q, thr_x_q) && inb(rd_y_q, mean_y_q, thr_y_q);

  logic [SqW:0] tx, ty;
  logic [SqW-1:0] bx, by;
  logic [SqW+CntW-1:0] rsx, rsy;
  assign rsx = {rem_x_q, num_x_q[SqW-1]};
  assign rsy = {rem_y_q, num_y_q[SqW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sig_x_q <= SigmaBits'(768);
      sig_y_q <= SigmaBits'(768);
      cnt_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      ridx_q <= '0;
      rd_v_q <= 1'b0;
      dstep_q <= '0;
      phase_q <= 1'b0;
      sstep_q <= '0;
      emit_q <= 1'b0;
      drop_q <= '0;
      res_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_ok_i) begin
        if (cfg_idx_i == RegSigmaX) sig_x_q <= cfg_data_i;
        else                        sig_y_q <= cfg_data_i;
      end
      if (cmd_i.load && (cnt_q < CntW'(MaxPairs))) begin
        cnt_q <= cnt_q + 1'b1;
        sum_x_q <= sum_x_q + SumW'(dx);
        sum_y_q <= sum_y_q + SumW'(dy);
      end
      if (cmd_i.clr) begin
        cnt_q <= '0;
        sum_x_q <= '0;
        sum_y_q <= '0;
        phase_q <= 1'b0;
      end
      ridx_q <= ridx_n;
      // read data of the next cycle belongs to the pass unless the pass just ended
      rd_v_q <= cmd_i.sum_start || cmd_i.cnt_start || cmd_i.emit_start ||
                ((cmd_i.sum_step || cmd_i.cnt_step || cmd_i.emit_step) &&
                 !sts_o.idx_last);
      emit_q <= cmd_i.emit_start || cmd_i.emit_step;

      // restoring division, one quotient bit per cycle
      if (cmd_i.div_start) begin
        dstep_q <= '0;
        rem_x_q <= '0;
        rem_y_q <= '0;
        num_x_q <= phase_q ? sq_x_q : SqW'(sum_x_q);
        num_y_q <= phase_q ? sq_y_q : SqW'(sum_y_q);
      end else if (cmd_i.div_step && dstep_q != 7'd64) begin
        dstep_q <= dstep_q + 7'd1;
        num_x_q <= num_x_q << 1;
        num_y_q <= num_y_q << 1;
        if (rsx >= (SqW+CntW)'(cnt_q)) begin
          rem_x_q <= CntW'(rsx - (SqW+CntW)'(cnt_q));
          quo_x_q <= {quo_x_q[SqW-2:0], 1'b1};
        end else begin
          rem_x_q <= CntW'(rsx);
          quo_x_q <= {quo_x_q[SqW-2:0], 1'b0};
        end
        if (rsy >= (SqW+CntW)'(cnt_q)) begin
          rem_y_q <= CntW'(rsy - (SqW+CntW)'(cnt_q));
          quo_y_q <= {quo_y_q[SqW-2:0], 1'b1};
        end else begin
          rem_y_q <= CntW'(rsy);
          quo_y_q <= {quo_y_q[SqW-2:0], 1'b0};
        end
      end
      if (cmd_i.div_fin) begin
        mean_x_q <= CoordBits'(quo_x_q);
        mean_y_q <= CoordBits'(quo_y_q);
        phase_q <= 1'b1;
        dstep_q <= '0;
      end

      // squared deviations, saturating accumulate
      if (cmd_i.sum_start) begin
        sq_x_q <= '0;
        sq_y_q <= '0;
      end else if (rd_v_q && !emit_q && phase_q && sstep_q == '0 && !cmd_i.cnt_step) begin
        if (tx[SqW]) sq_x_q <= '1; else sq_x_q <= tx[SqW-1:0];
        if (ty[SqW]) sq_y_q <= '1; else sq_y_q <= ty[SqW-1:0];
      end

      // bitwise integer square root, one result bit per cycle
      if (cmd_i.sqrt_start) begin
        sv_x_q <= quo_x_q;
        sv_y_q <= quo_y_q;
        sr_x_q <= '0;
        sr_y_q <= '0;
        sstep_q <= '0;
      end else if (cmd_i.sqrt_step && sstep_q != SqrtSteps) begin
        sstep_q <= sstep_q + 7'd1;
        if (sv_x_q >= sr_x_q + bx) begin
          sv_x_q <= sv_x_q - (sr_x_q + bx);
          sr_x_q <= (sr_x_q >> 1) + bx;
        end else sr_x_q <= sr_x_q >> 1;
        if (sv_y_q >= sr_y_q + by) begin
          sv_y_q <= sv_y_q - (sr_y_q + by);
          sr_y_q <= (sr_y_q >> 1) + by;
        end else sr_y_q <= sr_y_q >> 1;
      end
      if (cmd_i.thr_calc) begin
        drop_q <= '0;
        sstep_q <= 7'd127;
      end
      if (cmd_i.clr) sstep_q <= '0;
      if (rd_v_q && !emit_q && sstep_q == 7'd127 && !keep_now) drop_q <= drop_q + 7'd1;

      res_valid_o <= rd_v_q && emit_q;
      if (cmd_i.clr) drop_q <= '0;
    end
  end

  assign bx = SqW'(1) << (SqW - 2 - 2 * sstep_q[5:0]);
  assign by = bx;
  assign px = dvx * dvx;
  assign py = dvy * dvy;
  assign tx = {1'b0, sq_x_q} + (SqW+1)'(px);
  assign ty = {1'b0, sq_y_q} + (SqW+1)'(py);

  // threshold multiply after the root settles
  logic [ThrW+7:0] mx, my;
  assign rt_x_q = RtW'(sr_x_q);
  assign rt_y_q = RtW'(sr_y_q);
  assign mx = (ThrW+8)'(rt_x_q) * (ThrW+8)'(sig_x_q);
  assign my = (ThrW+8)'(rt_y_q) * (ThrW+8)'(sig_y_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.thr_calc) begin
      thr_x_q <= ThrW'(mx >> 8);
      thr_y_q <= ThrW'(my >> 8);
    end
    if (rd_v_q && emit_q) begin
      pair_index_o <= 6'(oidx_q);
      keep_pair_o <= keep_now;
      run_end_o <= sts_o.idx_last;
      dropped_total_o <= drop_q;
    end
    if (cmd_i.emit_start) oidx_q <= '0;
    else if (rd_v_q && emit_q) oidx_q <= oidx_q + 1'b1;
  end
endmodule
`default_nettype wire

/* rtl/core/scdf_checker.sv */
// port-level checker for the sigma-clip disparity filter, bound to the top level
`default_nettype none
module scdf_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic res_valid_o,
  input wire logic run_end_o,
  input wire logic keep_pair_o
);
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy) else $error("result while idle");
  a_end_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_end_o && res_valid_o |=> !res_valid_o) else $error("result after run end");
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy |=> !res_valid_o) else $error("result right after idle");
  a_keep_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !$isunknown({keep_pair_o, run_end_o})) else $error("unknown result flag");
endmodule

bind sigma_clip_disparity_filter_top scdf_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .res_valid_o, .run_end_o, .keep_pair_o
);
`default_nettype wire

/* verif/testbench.sv */
// testbench for the sigma-clip disparity filter: directed and random pair sets checked against a local predictor
`default_nettype none
module testbench
  import scdf_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxPairs = 64;
  localparam logic [1:0] RegIdxSigmaX = {1'b0, RegSigmaX};
  localparam logic [1:0] RegIdxSigmaY = {1'b0, RegSigmaY};
  localparam logic [1:0] RegIdxSpare2 = 2'd2;
  localparam logic [1:0] RegIdxSpare3 = 2'd3;

  typedef struct {
    logic [23:0] lcol;
    logic [23:0] lrow;
    logic [23:0] rcol;
    logic [23:0] rrow;
    logic        fin;
  } pair_t;

  typedef struct {
    logic [5:0] idx;
    logic       keep;
    logic [6:0] dropped;
    logic       last;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [23:0] left_col_i = '0, left_row_i = '0, right_col_i = '0, right_row_i = '0;
  logic final_pair_i = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [SigmaBits-1:0] cfg_data_i = '0;
  logic res_valid_o, keep_pair_o, run_end_o;
  logic [5:0] pair_index_o;
  logic [6:0] dropped_total_o;

  sigma_clip_disparity_filter_top i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [63:0] disp_x [MaxPairs];
  logic [63:0] disp_y [MaxPairs];
  int unsigned stored_n = 0;
  logic [63:0] sum_dx = 0, sum_dy = 0;
  logic [11:0] sigma_x = 12'd768, sigma_y = 12'd768;

  pair_t    pair_q[$];
  verdict_t verdict_q[$];
  int unsigned pushed_n = 0, taken_n = 0, errors = 0;
  bit no_gaps = 0;
  bit took = 0;
  int gap_cnt = 0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] band_width(input bit use_y, input logic [63:0] mean,
                                             input logic [11:0] sigma);
    logic [63:0] acc, d;
    acc = 0;
    for (int i = 0; i < stored_n; i++) begin
      d = use_y ? disp_y[i] : disp_x[i];
      d = (d >= mean) ? d - mean : mean - d;
      acc += d * d;
    end
    return (int_sqrt(acc / stored_n) * sigma) >> 8;
  endfunction

  function automatic bit within_band(input logic [63:0] d, input logic [63:0] m,
                                     input logic [63:0] t);
    return (d + t >= m) && (d <= m + t);
  endfunction

  task automatic predict_pair(input pair_t p);
    logic [63:0] mx, my, tx, ty;
    int unsigned drops;
    verdict_t v;
    if (stored_n < MaxPairs) begin
      disp_x[stored_n] = 64'((p.lcol >= p.rcol) ? p.lcol - p.rcol : p.rcol - p.lcol);
      disp_y[stored_n] = 64'((p.lrow >= p.rrow) ? p.lrow - p.rrow : p.rrow - p.lrow);
      sum_dx += disp_x[stored_n];
      sum_dy += disp_y[stored_n];
      stored_n++;
    end
    if (p.fin) begin
      mx = sum_dx / stored_n;
      my = sum_dy / stored_n;
      tx = band_width(0, mx, sigma_x);
      ty = band_width(1, my, sigma_y);
      drops = 0;
      for (int i = 0; i < stored_n; i++)
        if (!(within_band(disp_x[i], mx, tx) && within_band(disp_y[i], my, ty))) drops++;
      for (int i = 0; i < stored_n; i++) begin
        v.idx = i[5:0];
        v.keep = within_band(disp_x[i], mx, tx) && within_band(disp_y[i], my, ty);
        v.dropped = drops[6:0];
        v.last = (i + 1 == stored_n);
        verdict_q = {verdict_q, v};
      end
      stored_n = 0;
      sum_dx = 0;
      sum_dy = 0;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // input beat accepted here
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      predict_pair('{left_col_i, left_row_i, right_col_i, right_row_i, final_pair_i});
      taken_n++;
      took <= 1'b1;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took)) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
        start <= 1'b0;
      end else if (pair_q.size() != 0) begin
        pair_t p;
        p = pair_q.pop_front();
        left_col_i <= p.lcol;
        left_row_i <= p.lrow;
        right_col_i <= p.rcol;
        right_row_i <= p.rrow;
        final_pair_i <= p.fin;
        start <= 1'b1;
        gap_cnt <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
    took <= 1'b0;
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (verdict_q.size() == 0) begin
        report($sformatf("unexpected result index %0d", pair_index_o));
      end else begin
        verdict_t v;
        v = verdict_q.pop_front();
        if (pair_index_o !== v.idx)
          report($sformatf("pair_index %0d want %0d", pair_index_o, v.idx));
        if (keep_pair_o !== v.keep)
          report($sformatf("keep_pair %0b want %0b at %0d", keep_pair_o, v.keep, v.idx));
        if (dropped_total_o !== v.dropped)
          report($sformatf("dropped_total %0d want %0d", dropped_total_o, v.dropped));
        if (run_end_o !== v.last)
          report($sformatf("run_end %0b want %0b at %0d", run_end_o, v.last, v.idx));
      end
    end
  end

  task automatic push_pair(input logic [23:0] lc, lr, rc, rr, input logic fin);
    pair_t p;
    p = '{lc, lr, rc, rr, fin};
    pair_q = {pair_q, p};
    pushed_n++;
  endtask

  task automatic drain();
    while (taken_n != pushed_n || verdict_q.size() != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == RegIdxSigmaX) sigma_x = val;
    else if (idx == RegIdxSigmaY) sigma_y = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // one set: clustered disparities with a few outliers
  task automatic push_set(input int n);
    logic [23:0] lc, lr, off_x, off_y, cx, cy;
    cx = 24'($urandom_range(0, 4000));
    cy = 24'($urandom_range(0, 4000));
    for (int i = 0; i < n; i++) begin
      lc = 24'($urandom());
      lr = 24'($urandom());
      off_x = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                          : 24'(cx + $urandom_range(0, 600));
      off_y = ($urandom_range(0, 9) == 0) ? 24'($urandom())
                                          : 24'(cy + $urandom_range(0, 600));
      if ($urandom_range(0, 1)) off_x = -off_x;
      if ($urandom_range(0, 1)) off_y = -off_y;
      push_pair(lc, lr, lc + off_x, lr + off_y, i == n - 1);
    end
  endtask

  initial begin
    logic [11:0] sig_vals [5];
    int sz;
    sig_vals = '{12'd0, 12'd4095, 12'd256, 12'd768, 12'd1};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: single pairs at field extremes
    push_pair(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 1'b1);
    push_pair(24'h000000, 24'h000000, 24'h000000, 24'h000000, 1'b1);
    push_pair(24'hAAAAAA, 24'h555555, 24'h555555, 24'hAAAAAA, 1'b1);
    // symmetric set: with the reset sigma every pair falls inside the band
    push_pair(24'd1000, 24'd1000, 24'd1100, 24'd1100, 1'b0);
    push_pair(24'd1000, 24'd1000, 24'd1000, 24'd1000, 1'b0);
    push_pair(24'd1100, 24'd1100, 24'd1000, 24'd1000, 1'b0);
    push_pair(24'd0, 24'd0, 24'd0, 24'd0, 1'b1);
    push_pair(24'd10, 24'd10, 24'd20, 24'd10, 1'b0);
    push_pair(24'd10, 24'd10, 24'd20, 24'd10, 1'b0);
    push_pair(24'd10, 24'd10, 24'd10, 24'd900000, 1'b1);
    drain();
    // zero sigma: only disparities equal to the mean survive
    write_reg(RegIdxSigmaX, 12'd0);
    write_reg(RegIdxSigmaY, 12'd0);
    push_pair(24'd50, 24'd50, 24'd60, 24'd60, 1'b0);
    push_pair(24'd50, 24'd50, 24'd60, 24'd60, 1'b0);
    push_pair(24'd50, 24'd50, 24'd61, 24'd60, 1'b1);
    drain();
    // unused register indexes must be ignored
    write_reg(RegIdxSpare2, 12'hFFF);
    write_reg(RegIdxSpare3, 12'h000);
    write_reg(RegIdxSigmaX, 12'd4095);
    write_reg(RegIdxSigmaY, 12'd4095);
    push_set(6);
    drain();

    // full set with overflow pairs, final one arriving past the limit
    no_gaps = 1;
    write_reg(RegIdxSigmaX, 12'd256);
    write_reg(RegIdxSigmaY, 12'd512);
    push_set(MaxPairs + 1);
    pair_q[$].fin = 1'b0;
    push_pair(24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0, 1'b1);
    drain();
    no_gaps = 0;

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(RegIdxSigmaX, (ph % 3 == 2) ? 12'($urandom()) : sig_vals[ph % 5]);
      write_reg(RegIdxSigmaY, (ph % 4 == 3) ? 12'($urandom()) : sig_vals[(ph + 2) % 5]);
      no_gaps = (ph % 4 == 1);
      while (pushed_n < 66 + (ph + 1) * 24) begin
        sz = ($urandom_range(0, 19) == 0) ? $urandom_range(30, MaxPairs)
                                         : $urandom_range(1, 8);
        push_set(sz);
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("** sigma_clip_disparity_filter_top: PASSED **");
    end else begin
      $display("** sigma_clip_disparity_filter_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("** sigma_clip_disparity_filter_top: FAILED **");
    $finish;
  end
endmodule
`default_nettype wire
